>>> rtl/hthq_pkg.sv
`default_nettype none
package hthq_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned SampleW = 8;
  localparam int unsigned HeightW = 32;
  localparam int unsigned CellW   = 16;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam int unsigned DefMaxColumns = 256;
  localparam int unsigned DefMaxRows    = 256;
  localparam int unsigned CountLimit    = 256;

  localparam logic [CellW-1:0]   RstCellWidth  = 16'd256;
  localparam logic [CellW-1:0]   RstCellHeight = 16'd256;
  localparam logic [HeightW-1:0] RstZMin       = 32'd0;
  localparam logic [HeightW-1:0] RstZMax       = 32'd65280;
  localparam logic [CountW-1:0]  RstCount      = 9'd256;
  localparam logic [SampleW-1:0] SampleMax     = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELL_WIDTH  = 3'd0,
    CFG_CELL_HEIGHT = 3'd1,
    CFG_Z_MIN       = 3'd2,
    CFG_Z_MAX       = 3'd3,
    CFG_COLUMNS     = 3'd4,
    CFG_ROWS        = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

endpackage
`default_nettype wire

>>> rtl/hthq_if.sv
`default_nettype none
interface hthq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [hthq_pkg::IndexW-1:0]       grid_column;
  logic [hthq_pkg::IndexW-1:0]       grid_row;
  logic [hthq_pkg::SampleW-1:0]      sample_value;
  logic [hthq_pkg::CoordW-1:0]       query_x;
  logic [hthq_pkg::CoordW-1:0]       query_y;

  modport source (output valid, req_type, grid_column, grid_row, sample_value, query_x,
                  query_y, input ready);
  modport sink (input valid, req_type, grid_column, grid_row, sample_value, query_x,
                query_y, output ready);
endinterface

interface hthq_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [hthq_pkg::HeightW-1:0] terrain_height;
  logic                               out_of_range;

  modport source (output valid, terrain_height, out_of_range, input ready);
  modport sink (input valid, terrain_height, out_of_range, output ready);
endinterface
`default_nettype wire

>>> rtl/heightmap_triangle_height_query_top.sv
// Height map triangle height query.
// Requests arrive on req_i. A write request stores one 8-bit sample at a
// column and row and gives no result. A query request gives exactly one
// result on res_o: the interpolated height, or a flag with height zero when
// the point lies past the last cell of the configured grid.
// A query is served by one shared restoring divider that retires one
// quotient bit per cycle: two 24-bit divisions for the cell index and two
// 49-bit divisions for the interpolation, with one shared multiplier feeding
// it. Each of the three corner heights is divided by 255 with a shift and
// add reduction. req_i.ready is high only while no query is in progress.
// The result sits in an output register; a stalled receiver holds it, and
// the next query may run meanwhile but waits at its end until the register
// is free. Reset returns the configuration registers to their defaults and
// the sequencer to idle; the sample memory is not cleared, and a query must
// only use samples that were written. The user must write configuration
// through cfg_we_i, cfg_idx_i and cfg_data_i only while no request is in
// progress; the block itself does not enforce this.
`default_nettype none
module heightmap_triangle_height_query_top #(
  parameter int unsigned MAX_COLUMNS = hthq_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = hthq_pkg::DefMaxRows
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [hthq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [hthq_pkg::CfgW-1:0]       cfg_data_i,
  hthq_req_if.sink                       req_i,
  hthq_res_if.source                     res_o
);

  localparam int unsigned Depth  = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned ColLim = (MAX_COLUMNS < hthq_pkg::CountLimit) ?
                                   MAX_COLUMNS : hthq_pkg::CountLimit;
  localparam int unsigned RowLim = (MAX_ROWS < hthq_pkg::CountLimit) ?
                                   MAX_ROWS : hthq_pkg::CountLimit;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIV   = 13'b0000000000010,
    S_CHK   = 13'b0000000000100,
    S_TRI   = 13'b0000000001000,
    S_TRI2  = 13'b0000000010000,
    S_ADDR  = 13'b0000000100000,
    S_RDW   = 13'b0000001000000,
    S_CMUL  = 13'b0000010000000,
    S_CLOAD = 13'b0000100000000,
    S_IMUL  = 13'b0001000000000,
    S_ILOAD = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_R255  = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    OP_X      = 2'd0,
    OP_Y      = 2'd1,
    OP_INTERP = 2'd2
  } op_e;

  // Configuration registers.
  logic [15:0]        cw_q, ch_q;
  logic signed [31:0] zmin_q, zmax_q;
  logic [8:0]         ncol_q, nrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q   <= hthq_pkg::RstCellWidth;
      ch_q   <= hthq_pkg::RstCellHeight;
      zmin_q <= hthq_pkg::RstZMin;
      zmax_q <= hthq_pkg::RstZMax;
      ncol_q <= hthq_pkg::RstCount;
      nrow_q <= hthq_pkg::RstCount;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hthq_pkg::CFG_CELL_WIDTH:  cw_q   <= cfg_data_i[15:0];
        hthq_pkg::CFG_CELL_HEIGHT: ch_q   <= cfg_data_i[15:0];
        hthq_pkg::CFG_Z_MIN:       zmin_q <= cfg_data_i;
        hthq_pkg::CFG_Z_MAX:       zmax_q <= cfg_data_i;
        hthq_pkg::CFG_COLUMNS:     ncol_q <= cfg_data_i[8:0];
        hthq_pkg::CFG_ROWS:        nrow_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  k_q, k_d;
  logic        i_q, i_d;
  logic        ov_q, ov_d;

  logic [48:0] dvd_q, dvd_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [23:0] qy_q, qy_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic [8:0]  cols_q, cols_d, rows_q, rows_d;
  logic [23:0] icol_q, icol_d, irow_q, irow_d;
  logic [15:0] dx_q, dx_d, dy_q, dy_d;
  logic [31:0] t_q, t_d;
  logic        up_q, up_d;
  logic        oor_q, oor_d;
  logic [15:0] fx_q, fx_d, fy_q, fy_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [7:0]  rd_q;
  logic [32:0] smag_q, smag_d;
  logic        sneg_q, sneg_d;
  logic [32:0] quo_q, quo_d;
  logic signed [31:0] c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic signed [34:0] acc_q, acc_d;
  logic signed [50:0] prod_q;
  logic signed [31:0] oh_q, oh_d;
  logic        oo_q, oo_d;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;

  // One quotient bit of the shared divider.
  logic [16:0] rem_sh;
  logic        ge;
  logic [15:0] rem_nx;
  logic [48:0] dvd_nx;
  logic signed [34:0] qs;

  assign rem_sh = {rem_q, dvd_q[48]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
  assign dvd_nx = {dvd_q[47:0], ge};
  assign qs     = neg_q ? -$signed({1'b0, dvd_nx[33:0]}) : $signed({1'b0, dvd_nx[33:0]});

  // Division by 255: v = 256*q + r = 255*q + (q + r), so v/255 = q + (q + r)/255.
  logic [40:0] r255_nx;
  logic        r255_done;
  logic [32:0] quo_nx;
  logic [33:0] cmag;

  assign r255_done = (dvd_q[40:8] == 33'd0);
  assign r255_nx   = {8'd0, dvd_q[40:8]} + {33'd0, dvd_q[7:0]};
  assign quo_nx    = r255_done ?
                     quo_q + {32'd0, (dvd_q[7:0] == hthq_pkg::SampleMax)} :
                     quo_q + dvd_q[40:8];
  assign cmag      = {1'b0, quo_nx};

  logic        acc_req, wr_en;
  logic [AddrW-1:0] waddr;
  logic signed [32:0] span;
  logic [8:0]  ccol, crow;
  logic        colp, rowp;
  logic [33:0] csum;
  logic [50:0] pmag;
  logic signed [31:0] sat;

  assign req_i.ready = (state_q == S_IDLE);
  assign acc_req     = req_i.valid && req_i.ready;
  assign wr_en       = acc_req && (req_i.req_type == hthq_pkg::REQ_WRITE) &&
                       ({24'd0, req_i.grid_column} < 32'(MAX_COLUMNS)) &&
                       ({24'd0, req_i.grid_row} < 32'(MAX_ROWS));
  assign waddr       = AddrW'(AddrW'(req_i.grid_column) * AddrW'(MAX_ROWS)) +
                       AddrW'(req_i.grid_row);
  assign span        = $signed({zmax_q[31], zmax_q}) - $signed({zmin_q[31], zmin_q});
  assign colp        = up_q ? (k_q != 2'd1) : (k_q == 2'd1);
  assign rowp        = up_q ? (k_q != 2'd2) : (k_q == 2'd2);
  assign ccol        = icol_q[8:0] + {8'd0, colp};
  assign crow        = irow_q[8:0] + {8'd0, rowp};
  assign csum        = {{2{zmin_q[31]}}, zmin_q} + (sneg_q ? (~cmag + 34'd1) : cmag);
  assign pmag        = prod_q[50] ? 51'(-prod_q) : prod_q;
  assign sat         = (acc_q > 35'sd2147483647) ? 32'sh7fffffff :
                       (acc_q < -35'sd2147483648) ? 32'sh80000000 : acc_q[31:0];

  always_comb begin
    state_d = state_q;  op_d = op_q;  cnt_d = cnt_q;  k_d = k_q;  i_d = i_q;
    dvd_d = dvd_q;  rem_d = rem_q;  dvs_d = dvs_q;  neg_d = neg_q;  qy_d = qy_q;
    w_d = w_q;  h_d = h_q;  cols_d = cols_q;  rows_d = rows_q;
    icol_d = icol_q;  irow_d = irow_q;  dx_d = dx_q;  dy_d = dy_q;
    t_d = t_q;  up_d = up_q;  oor_d = oor_q;  fx_d = fx_q;  fy_d = fy_q;
    addr_d = addr_q;  smag_d = smag_q;  sneg_d = sneg_q;  quo_d = quo_q;
    c0_d = c0_q;  c1_d = c1_q;  c2_d = c2_q;  acc_d = acc_q;
    oh_d = oh_q;  oo_d = oo_q;
    ov_d = ov_q && !res_o.ready;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE: begin
        if (acc_req && (req_i.req_type == hthq_pkg::REQ_QUERY)) begin
          w_d    = (cw_q == 16'd0) ? 16'd1 : cw_q;
          h_d    = (ch_q == 16'd0) ? 16'd1 : ch_q;
          cols_d = (ncol_q < 9'd2) ? 9'd2 : (ncol_q > 9'(ColLim)) ? 9'(ColLim) : ncol_q;
          rows_d = (nrow_q < 9'd2) ? 9'd2 : (nrow_q > 9'(RowLim)) ? 9'(RowLim) : nrow_q;
          qy_d   = req_i.query_y;
          dvd_d  = {req_i.query_x, 25'd0};
          rem_d  = '0;
          dvs_d  = (cw_q == 16'd0) ? 16'd1 : cw_q;
          neg_d  = 1'b0;
          cnt_d  = 6'd24;
          op_d   = OP_X;
          sneg_d = span[32];
          smag_d = span[32] ? 33'(-span) : span;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        dvd_d = dvd_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          case (op_q)
            OP_X: begin
              icol_d = dvd_nx[23:0];
              dx_d   = rem_nx;
              dvd_d  = {qy_q, 25'd0};
              rem_d  = '0;
              dvs_d  = h_q;
              cnt_d  = 6'd24;
              op_d   = OP_Y;
            end
            OP_Y: begin
              irow_d  = dvd_nx[23:0];
              dy_d    = rem_nx;
              state_d = S_CHK;
            end
            default: begin
              acc_d = acc_q + qs;
              if (i_q) begin
                oor_d   = 1'b0;
                state_d = S_FIN;
              end else begin
                i_d     = 1'b1;
                state_d = S_IMUL;
              end
            end
          endcase
        end
      end
      S_CHK: begin
        if (({1'b0, icol_q} + 25'd1 >= 25'(cols_q)) ||
            ({1'b0, irow_q} + 25'd1 >= 25'(rows_q))) begin
          oor_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          mul_a   = 34'(dy_q);
          mul_b   = 17'(w_q);
          state_d = S_TRI;
        end
      end
      S_TRI: begin
        t_d     = prod_q[31:0];
        mul_a   = 34'(16'(w_q - dx_q));
        mul_b   = 17'(h_q);
        state_d = S_TRI2;
      end
      S_TRI2: begin
        up_d    = !(t_q <= prod_q[31:0]);
        fx_d    = (t_q <= prod_q[31:0]) ? dx_q : 16'(w_q - dx_q);
        fy_d    = (t_q <= prod_q[31:0]) ? dy_q : 16'(h_q - dy_q);
        k_d     = 2'd0;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        addr_d  = AddrW'(AddrW'(ccol) * AddrW'(MAX_ROWS)) + AddrW'(crow);
        state_d = S_RDW;
      end
      S_RDW: state_d = S_CMUL;
      S_CMUL: begin
        mul_a   = {1'b0, smag_q};
        mul_b   = {9'd0, 8'(hthq_pkg::SampleMax - rd_q)};
        state_d = S_CLOAD;
      end
      S_CLOAD: begin
        dvd_d   = {8'd0, prod_q[40:0]};
        quo_d   = '0;
        state_d = S_R255;
      end
      S_R255: begin
        dvd_d = {8'd0, r255_nx};
        quo_d = quo_nx;
        if (r255_done) begin
          case (k_q)
            2'd0:    c0_d = csum[31:0];
            2'd1:    c1_d = csum[31:0];
            default: c2_d = csum[31:0];
          endcase
          if (k_q == 2'd2) begin
            acc_d   = {{3{c0_q[31]}}, c0_q};
            i_d     = 1'b0;
            state_d = S_IMUL;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_ADDR;
          end
        end
      end
      S_IMUL: begin
        mul_a   = i_q ? 34'({c2_q[31], c2_q} - {c0_q[31], c0_q}) :
                        34'({c1_q[31], c1_q} - {c0_q[31], c0_q});
        mul_a   = {mul_a[32], mul_a[32:0]};
        mul_b   = {1'b0, i_q ? fy_q : fx_q};
        state_d = S_ILOAD;
      end
      S_ILOAD: begin
        dvd_d   = pmag[48:0];
        rem_d   = '0;
        dvs_d   = i_q ? h_q : w_q;
        neg_d   = prod_q[50];
        cnt_d   = 6'd49;
        op_d    = OP_INTERP;
        state_d = S_DIV;
      end
      S_FIN: begin
        if (!ov_q || res_o.ready) begin
          ov_d    = 1'b1;
          oh_d    = oor_q ? 32'sd0 : sat;
          oo_d    = oor_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_X;
      cnt_q   <= '0;
      k_q     <= '0;
      i_q     <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;   rem_q  <= rem_d;   dvs_q  <= dvs_d;   neg_q  <= neg_d;
    qy_q   <= qy_d;    w_q    <= w_d;     h_q    <= h_d;
    cols_q <= cols_d;  rows_q <= rows_d;
    icol_q <= icol_d;  irow_q <= irow_d;  dx_q   <= dx_d;    dy_q   <= dy_d;
    t_q    <= t_d;     up_q   <= up_d;    oor_q  <= oor_d;
    fx_q   <= fx_d;    fy_q   <= fy_d;    addr_q <= addr_d;
    smag_q <= smag_d;  sneg_q <= sneg_d;  quo_q  <= quo_d;
    c0_q   <= c0_d;    c1_q   <= c1_d;    c2_q   <= c2_d;    acc_q  <= acc_d;
    oh_q   <= oh_d;    oo_q   <= oo_d;
    prod_q <= mul_a * mul_b;
  end

  logic [7:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= req_i.sample_value;
    end
    rd_q <= mem[addr_q];
  end

  assign res_o.valid          = ov_q;
  assign res_o.terrain_height = oh_q;
  assign res_o.out_of_range   = oo_q;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_of_range |-> res_o.terrain_height == 32'sd0)
    else $error("flagged result carries a non-zero height");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q != 6'd0)
    else $error("divider running with an empty bit count");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_req && req_i.req_type == hthq_pkg::REQ_WRITE |=> state_q == S_IDLE)
    else $error("write request left the sequencer busy");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && (!ov_q || res_o.ready) |=> res_o.valid)
    else $error("finished request did not reach the output register");

endmodule
`default_nettype wire

>>> tb/testbench.sv
module testbench;

  typedef struct {
    hthq_pkg::req_type_e kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [7:0]  val;
    logic [23:0] x;
    logic [23:0] y;
  } request_t;

  typedef struct {
    logic signed [31:0] height;
    bit                 flag;
  } height_t;

  typedef struct {
    request_t           rq;
    bit                 typed;
    logic signed [31:0] height;
    bit                 flag;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [hthq_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [hthq_pkg::CfgW-1:0] cfg_data_i = '0;

  hthq_req_if req_if();
  hthq_res_if res_if();

  heightmap_triangle_height_query_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req_i(req_if), .res_o(res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0] samples [256][256];
  bit written [256][256];
  longint cell_w, cell_h, z_lo, z_hi, cols_cfg, rows_cfg;
  height_t pending_heights[$];
  int errors = 0;
  int cycles = 0;
  int sent_in_phase;
  bit calm;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint clamp_count(longint v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic longint corner_height(int c, int r);
    longint p;
    p = samples[c][r];
    return z_lo + ((255 - p) * (z_hi - z_lo)) / 255;
  endfunction

  function automatic height_t predict_height(request_t rq);
    height_t e;
    longint w, h, icol, irow, dx, dy, res, a, b, d;
    w = (cell_w == 0) ? 1 : cell_w;
    h = (cell_h == 0) ? 1 : cell_h;
    icol = rq.x / w;
    irow = rq.y / h;
    e.height = 0;
    e.flag = 1'b1;
    if (icol + 1 >= clamp_count(cols_cfg) || irow + 1 >= clamp_count(rows_cfg)) return e;
    dx = rq.x - icol * w;
    dy = rq.y - irow * h;
    b = corner_height(int'(icol + 1), int'(irow));
    d = corner_height(int'(icol), int'(irow + 1));
    if (dy * w <= (w - dx) * h) begin
      a = corner_height(int'(icol), int'(irow));
      res = a + ((b - a) * dx) / w + ((d - a) * dy) / h;
    end else begin
      a = corner_height(int'(icol + 1), int'(irow + 1));
      res = a + ((d - a) * (w - dx)) / w + ((b - a) * (h - dy)) / h;
    end
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    e.height = res[31:0];
    e.flag = 1'b0;
    return e;
  endfunction

  task automatic send_request(request_t rq, bit typed = 0, logic signed [31:0] th = 0,
                              bit tf = 0);
    int gap;
    height_t e;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.req_type <= rq.kind;
    req_if.grid_column <= rq.col;
    req_if.grid_row <= rq.row;
    req_if.sample_value <= rq.val;
    req_if.query_x <= rq.x;
    req_if.query_y <= rq.y;
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    if (rq.kind == hthq_pkg::REQ_WRITE) begin
      samples[rq.col][rq.row] = rq.val;
      written[rq.col][rq.row] = 1'b1;
    end else begin
      e = predict_height(rq);
      if (typed) begin
        e.height = th;
        e.flag = tf;
      end
      pending_heights = {pending_heights, e};
    end
    sent_in_phase++;
  endtask

  task automatic write_sample(int c, int r, int v);
    request_t rq;
    rq = '{hthq_pkg::REQ_WRITE, c[7:0], r[7:0], v[7:0], 24'($urandom()), 24'($urandom())};
    send_request(rq);
  endtask

  // Corners that a query would read are written first when still unknown.
  task automatic query_point(longint x, longint y);
    request_t rq;
    longint w, h, icol, irow;
    w = (cell_w == 0) ? 1 : cell_w;
    h = (cell_h == 0) ? 1 : cell_h;
    icol = x / w;
    irow = y / h;
    if (icol + 1 < clamp_count(cols_cfg) && irow + 1 < clamp_count(rows_cfg)) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (!written[icol + i][irow + j])
            write_sample(int'(icol + i), int'(irow + j), $urandom_range(0, 255));
        end
      end
    end
    rq = '{hthq_pkg::REQ_QUERY, 8'($urandom()), 8'($urandom()), 8'($urandom()),
           x[23:0], y[23:0]};
    send_request(rq);
  endtask

  function automatic longint pick_coord(longint size, longint count);
    longint span, idx, v;
    span = (size == 0) ? 1 : size;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 24'hFFFFFF);
      1: return (clamp_count(count) - 1) * span + $urandom_range(0, 300);
      default: begin
        idx = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 254 : 6);
        v = idx * span + $urandom_range(0, span - 1);
        return (v > 24'hFFFFFF) ? $urandom_range(0, 24'hFFFFFF) : v;
      end
    endcase
  endfunction

  task automatic write_config(longint w, longint h, longint zl, longint zh, longint c,
                              longint r);
    logic [31:0] vals [6];
    vals = '{w[31:0], h[31:0], zl[31:0], zh[31:0], c[31:0], r[31:0]};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= hthq_pkg::cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cell_w = w[15:0];
    cell_h = h[15:0];
    z_lo = longint'($signed(zl[31:0]));
    z_hi = longint'($signed(zh[31:0]));
    cols_cfg = c[8:0];
    rows_cfg = r[8:0];
  endtask

  task automatic drain;
    req_if.valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      int stall;
      height_t e;
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      if (pending_heights.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d", res_if.terrain_height);
      end else begin
        e = pending_heights.pop_front();
        if (res_if.terrain_height !== e.height || res_if.out_of_range !== e.flag) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%0b, got %0d/%0b", e.height, e.flag,
                     res_if.terrain_height, res_if.out_of_range);
        end
      end
    end
  end

  row_t table_rows [] = '{
    '{'{hthq_pkg::REQ_WRITE, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_WRITE, 8'd1, 8'd0, 8'd0, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_WRITE, 8'd0, 8'd1, 8'd0, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_WRITE, 8'd1, 8'd1, 8'd255, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0}, 1, 65280, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd255, 24'd255}, 1, 510, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd128, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd100, 24'd200}, 0, 0, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd200, 24'd100}, 0, 0, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd65280, 24'd0}, 1, 0, 1},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd0, 24'd65280}, 1, 0, 1},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'hFFFFFF, 24'hFFFFFF}, 1, 0, 1},
    '{'{hthq_pkg::REQ_WRITE, 8'd255, 8'd255, 8'd255, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_WRITE, 8'd254, 8'd254, 8'd128, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_WRITE, 8'd255, 8'd254, 8'd1, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_WRITE, 8'd254, 8'd255, 8'd77, 24'd0, 24'd0}, 0, 0, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd65279, 24'd65279}, 0, 0, 0},
    '{'{hthq_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, 24'd65024, 24'd65024}, 0, 0, 0}
  };

  initial begin
    longint settings [6][6];
    req_if.valid = 1'b0;
    req_if.req_type = hthq_pkg::REQ_WRITE;
    req_if.grid_column = '0;
    req_if.grid_row = '0;
    req_if.sample_value = '0;
    req_if.query_x = '0;
    req_if.query_y = '0;
    cell_w = hthq_pkg::RstCellWidth;
    cell_h = hthq_pkg::RstCellHeight;
    z_lo = 0;
    z_hi = hthq_pkg::RstZMax;
    cols_cfg = hthq_pkg::RstCount;
    rows_cfg = hthq_pkg::RstCount;
    foreach (samples[i, j]) samples[i][j] = '0;
    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_request(table_rows[i].rq, table_rows[i].typed, table_rows[i].height,
                   table_rows[i].flag);
    drain();

    settings = '{
      '{1, 1, 0, 65280, 2, 2},
      '{65535, 65535, -64'sd2147483648, 64'sd2147483647, 256, 256},
      '{0, 0, 500, 500, 0, 1},
      '{300, 77, 1000, -5000, 511, 300},
      '{256, 512, 64'sd2147483647, -64'sd2147483648, 16, 9},
      '{40, 1000, -123456, 987654, 257, 3}
    };
    for (int p = 0; p < 10; p++) begin
      if (p < 6)
        write_config(settings[p][0], settings[p][1], settings[p][2], settings[p][3],
                     settings[p][4], settings[p][5]);
      else
        write_config($urandom_range(1, 2000), $urandom_range(1, 2000), $signed($urandom()),
                     $signed($urandom()), $urandom_range(0, 511), $urandom_range(0, 511));
      calm = ($urandom_range(0, 3) == 0);
      sent_in_phase = 0;
      while (sent_in_phase < 90) begin
        if (p == 2 && sent_in_phase > 40 && sent_in_phase < 46) begin
          req_if.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_heights.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 6) == 0)
          write_sample($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        else
          query_point(pick_coord(cell_w, cols_cfg), pick_coord(cell_h, rows_cfg));
      end
      drain();
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
